FILE: rtl/svd_pkg.sv
// Shared constants, codes and table builders for the sine voice with decay.
package svd_pkg;

	typedef logic [63:0] u64_t;

	localparam int DEF_SAMPLE_RATE     = 48000;
	localparam int DEF_SINE_INDEX_BITS = 10;
	localparam int DEF_SAMPLE_BITS     = 16;

	localparam int PHASE_BITS     = 32;
	localparam int LEVEL_BITS     = 16;
	localparam int TAIL_FRAC_BITS = 15;
	localparam int NOTE_BITS      = 7;
	localparam int VEL_BITS       = 7;
	localparam int NOTE_COUNT     = 1 << NOTE_BITS;
	localparam int ACTION_BITS    = 2;
	localparam int IN_DATA_W      = 16;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [LEVEL_BITS-1:0] TAIL_ONE        = 16'd32768;
	localparam logic [LEVEL_BITS-1:0] LEVEL_SCALE_RST = 16'd9830;
	localparam logic [LEVEL_BITS-1:0] DECAY_RST       = 16'd64881;
	localparam logic [LEVEL_BITS-1:0] THRESH_RST      = 16'd164;

	// velocity * level_scale rounded and divided by 127, bit-serial
	localparam int DIV_W         = VEL_BITS + LEVEL_BITS;
	localparam int DIV_REM_W     = 7;
	localparam int LEVEL_DIVISOR = 127;
	localparam int LEVEL_ROUND   = 63;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_TICK      = 2'd0,
		ACT_START     = 2'd1,
		ACT_STOP_TAIL = 2'd2,
		ACT_STOP_NOW  = 2'd3
	} action_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LEVEL_SCALE    = 2'd0,
		REG_DECAY_FACTOR   = 2'd1,
		REG_STOP_THRESHOLD = 2'd2
	} reg_index_t;

	localparam u64_t ONE_Q30     = 64'd1 << 30;
	localparam u64_t HALF_PI_Q30 = 64'd1686629713;
	localparam u64_t TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210};
	localparam int unsigned SEMITONES = 12;

	// sin(x), x in [0, pi/2], Q2.30 in and out
	function automatic u64_t sin_q30(input u64_t x);
		u64_t x2;
		u64_t term;
		u64_t sum;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int k = 1; k <= 7; k++) begin
			term = (term * x2) >> 30;
			term = term / TAYLOR_DIV[k];
			if ((k & 1) != 0)
				sum = sum - term;
			else
				sum = sum + term;
		end
		return (sum > ONE_Q30) ? ONE_Q30 : sum;
	endfunction

	// one sine table entry, two's complement in 32 bits
	function automatic logic [31:0] sine_entry(input int unsigned idx, input int unsigned ib,
		input int unsigned sb);
		int unsigned quarter;
		int unsigned quad;
		int unsigned r;
		int unsigned y;
		u64_t x;
		u64_t fs;
		u64_t m;
		quarter = 1 << (ib - 2);
		quad = idx >> (ib - 2);
		r = idx & (quarter - 1);
		y = ((quad & 1) != 0) ? quarter - r : r;
		x = (HALF_PI_Q30 * u64_t'(y)) >> (ib - 2);
		fs = (u64_t'(1) << (sb - 1)) - u64_t'(1);
		m = (sin_q30(x) * fs + (u64_t'(1) << 29)) >> 30;
		return ((quad & 2) != 0) ? 32'(u64_t'(0) - m) : 32'(m);
	endfunction

	function automatic u64_t pow12_q30(input u64_t x);
		u64_t p;
		p = x;
		for (int i = 0; i < 11; i++)
			p = (p * x) >> 30;
		return p;
	endfunction

	// twelfth root of two in Q2.30 by bisection
	function automatic u64_t semitone_q30();
		u64_t lo;
		u64_t hi;
		u64_t mid;
		lo = ONE_Q30;
		hi = ONE_Q30 + (u64_t'(1) << 26);
		while (hi - lo > u64_t'(1)) begin
			mid = (lo + hi) >> 1;
			if (pow12_q30(mid) <= (u64_t'(2) << 30))
				lo = mid;
			else
				hi = mid;
		end
		return lo;
	endfunction

	// 32-bit phase increment for a MIDI note; a16 = 440 Hz / fs in Q.48
	function automatic logic [31:0] note_step(input int unsigned n, input u64_t a16,
		input u64_t semi);
		int unsigned m;
		int unsigned oct;
		int unsigned idx;
		int unsigned s;
		u64_t rt;
		u64_t v;
		m = n + 3;
		oct = m / SEMITONES;
		idx = m % SEMITONES;
		rt = ONE_Q30;
		for (int i = 1; i < 12; i++)
			if (i <= idx)
				rt = (rt * semi + (u64_t'(1) << 29)) >> 30;
		v = a16 * (rt >> 15) + ((a16 * (rt & 64'h7FFF)) >> 15);
		s = 37 - oct;
		return 32'((v + (u64_t'(1) << (s - 1))) >> s);
	endfunction

endpackage

FILE: rtl/svd_serial_mul.sv
// Radix-4 serial shift-add multiplier, two multiplier bits per cycle.
module svd_serial_mul #(
	parameter int A_W = svd_pkg::LEVEL_BITS,
	parameter int B_W = svd_pkg::LEVEL_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               done,
	output logic [A_W+B_W-1:0] product
);
	import svd_pkg::*;

	localparam int STEPS = B_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [A_W-1:0]     a_q;
	logic [A_W+B_W-1:0] p_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [A_W+1:0]     pp;
	logic [A_W+1:0]     acc;

	always_comb begin
		unique case (p_q[1:0])
			2'd0: pp = '0;
			2'd1: pp = {2'b00, a_q};
			2'd2: pp = {1'b0, a_q, 1'b0};
			2'd3: pp = {2'b00, a_q} + {1'b0, a_q, 1'b0};
		endcase
		acc = {2'b00, p_q[A_W+B_W-1:B_W]} + pp;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{A_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {acc, p_q[B_W-1:2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign product = p_q;

endmodule

FILE: rtl/sine_voice_with_decay_top.sv
// One sine synth voice with exponential tail-off. Each accepted transaction on the slave
// stream is one action: a tick returns one sample on the master stream, a note start or
// either stop returns nothing. A sounding tick makes one or two passes through the
// radix-4 serial multiplier, two while the tail decays; a tick on a silent voice skips
// them. A note start runs the bit-serial divide of velocity times level_scale by 127;
// the stops are handled in the idle state. Registers are written on the cfg channel
// (index 0 level_scale, 1 decay_factor, 2 stop_threshold); the user must write them only
// while the voice is idle, as the block itself does not enforce this.
module sine_voice_with_decay_top #(
	parameter int SAMPLE_RATE     = svd_pkg::DEF_SAMPLE_RATE,
	parameter int SINE_INDEX_BITS = svd_pkg::DEF_SINE_INDEX_BITS,
	parameter int SAMPLE_BITS     = svd_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [svd_pkg::IN_DATA_W-1:0]           s_axis_tdata,  // note_number, velocity
	input  logic [svd_pkg::ACTION_BITS-1:0]         s_axis_tuser,  // action
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] m_axis_tdata, // sample, voice_active
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [svd_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  logic [svd_pkg::LEVEL_BITS-1:0]          cfg_data
);
	import svd_pkg::*;

	localparam int   OUT_DATA_W = ((SAMPLE_BITS + 8) / 8) * 8;
	localparam int   SINE_SIZE  = 1 << SINE_INDEX_BITS;
	localparam int   MA_W       = SAMPLE_BITS - 1 + LEVEL_BITS;
	localparam int   P_W        = MA_W + LEVEL_BITS;
	localparam int   RND_TAIL   = LEVEL_BITS + TAIL_FRAC_BITS;
	localparam int   DIV_CNT_W  = $clog2(DIV_W + 1);
	localparam u64_t A16  = ((64'd440 << 48) + u64_t'(SAMPLE_RATE / 2)) / u64_t'(SAMPLE_RATE);
	localparam u64_t SEMI = semitone_q30();

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_LOAD, S_MUL1, S_MUL2, S_FIN, S_EMIT
	} state_t;

	logic [SAMPLE_BITS-1:0] sine_rom [SINE_SIZE];
	logic [PHASE_BITS-1:0]  note_rom [NOTE_COUNT];

	for (genvar g = 0; g < SINE_SIZE; g++) begin : g_sine
		localparam logic [31:0] ENTRY = sine_entry(g, SINE_INDEX_BITS, SAMPLE_BITS);
		assign sine_rom[g] = ENTRY[SAMPLE_BITS-1:0];
	end

	for (genvar g = 0; g < NOTE_COUNT; g++) begin : g_note
		localparam logic [31:0] STEP = note_step(g, A16, SEMI);
		assign note_rom[g] = STEP;
	end

	state_t                  state_q;
	logic [LEVEL_BITS-1:0]   level_scale_q;
	logic [LEVEL_BITS-1:0]   decay_q;
	logic [LEVEL_BITS-1:0]   thresh_q;
	logic [PHASE_BITS-1:0]   phase_q;
	logic [PHASE_BITS-1:0]   inc_q;
	logic [LEVEL_BITS-1:0]   level_q;
	logic [LEVEL_BITS-1:0]   tail_q;
	logic                    sounding_q;
	logic [SAMPLE_BITS-1:0]  rom_q;
	logic                    neg_q;
	logic [DIV_W-1:0]        div_n_q;
	logic [DIV_REM_W-1:0]    div_r_q;
	logic [DIV_CNT_W-1:0]    div_cnt_q;
	logic [MA_W-1:0]         mul_a_q;
	logic [LEVEL_BITS-1:0]   mul_b_q;
	logic                    mul_start_q;
	logic                    tmul_start_q;
	logic [SAMPLE_BITS-1:0]  res_sample_q;
	logic                    res_active_q;
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;

	logic                    in_fire;
	action_t                 act;
	logic [NOTE_BITS-1:0]    note;
	logic [VEL_BITS-1:0]     vel;
	logic [DIV_W-1:0]        div_load;
	logic [DIV_REM_W:0]      div_trial;
	logic                    div_ge;
	logic [DIV_REM_W-1:0]    div_rem_next;
	logic [DIV_W-1:0]        div_n_next;
	logic [SAMPLE_BITS-1:0]  rom_abs;
	logic                    mul_done;
	logic [P_W-1:0]          mul_p;
	logic                    tmul_done;
	logic [2*LEVEL_BITS-1:0] tmul_p;
	logic [2*LEVEL_BITS-1:0] tail_sum;
	logic [LEVEL_BITS-1:0]   tail_new;
	logic [P_W-1:0]          rnd_tail_sum;
	logic [P_W-1:0]          rnd_plain_sum;
	logic [SAMPLE_BITS-1:0]  mag_rnd;

	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		act  = action_t'(s_axis_tuser);
		note = s_axis_tdata[NOTE_BITS-1:0];
		vel  = s_axis_tdata[NOTE_BITS +: VEL_BITS];
		div_load = DIV_W'(vel) * DIV_W'(level_scale_q) + DIV_W'(LEVEL_ROUND);

		div_trial    = {div_r_q, div_n_q[DIV_W-1]};
		div_ge       = (div_trial >= (DIV_REM_W + 1)'(LEVEL_DIVISOR));
		div_rem_next = div_ge ? DIV_REM_W'(div_trial - (DIV_REM_W + 1)'(LEVEL_DIVISOR))
		                      : div_trial[DIV_REM_W-1:0];
		div_n_next   = {div_n_q[DIV_W-2:0], div_ge};

		rom_abs = rom_q[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - rom_q) : rom_q;

		tail_sum = tmul_p + (2 * LEVEL_BITS)'(TAIL_ONE);
		tail_new = tail_sum[2*LEVEL_BITS-1:LEVEL_BITS];

		rnd_tail_sum  = mul_p + (P_W'(1) << (RND_TAIL - 1));
		rnd_plain_sum = mul_p + (P_W'(1) << (LEVEL_BITS - 1));
		mag_rnd = (tail_q != '0) ? rnd_tail_sum[P_W-1 -: SAMPLE_BITS]
		                         : rnd_plain_sum[LEVEL_BITS +: SAMPLE_BITS];
	end

	svd_serial_mul #(
		.A_W(MA_W),
		.B_W(LEVEL_BITS)
	) u_level_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.product(mul_p)
	);

	svd_serial_mul #(
		.A_W(LEVEL_BITS),
		.B_W(LEVEL_BITS)
	) u_tail_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tmul_start_q),
		.a      (tail_q),
		.b      (decay_q),
		.done   (tmul_done),
		.product(tmul_p)
	);

	always_ff @(posedge clk) begin
		rom_q <= sine_rom[phase_q[PHASE_BITS-1 -: SINE_INDEX_BITS]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			level_scale_q <= LEVEL_SCALE_RST;
			decay_q       <= DECAY_RST;
			thresh_q      <= THRESH_RST;
			phase_q       <= '0;
			inc_q         <= '0;
			level_q       <= '0;
			tail_q        <= '0;
			sounding_q    <= 1'b0;
			neg_q         <= 1'b0;
			div_n_q       <= '0;
			div_r_q       <= '0;
			div_cnt_q     <= '0;
			mul_a_q       <= '0;
			mul_b_q       <= '0;
			mul_start_q   <= 1'b0;
			tmul_start_q  <= 1'b0;
			res_sample_q  <= '0;
			res_active_q  <= 1'b0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			mul_start_q  <= 1'b0;
			tmul_start_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_LEVEL_SCALE:    level_scale_q <= cfg_data;
					REG_DECAY_FACTOR:   decay_q       <= cfg_data;
					REG_STOP_THRESHOLD: thresh_q      <= cfg_data;
					default: ;
				endcase
			end

			if (m_axis_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						unique case (act)
							ACT_START: begin
								phase_q    <= '0;
								tail_q     <= '0;
								inc_q      <= note_rom[note];
								sounding_q <= 1'b1;
								div_n_q    <= div_load;
								div_r_q    <= '0;
								div_cnt_q  <= DIV_CNT_W'(DIV_W);
								state_q    <= S_DIV;
							end
							ACT_STOP_TAIL: begin
								if (tail_q == '0)
									tail_q <= TAIL_ONE;
							end
							ACT_STOP_NOW: begin
								sounding_q <= 1'b0;
								inc_q      <= '0;
							end
							ACT_TICK: begin
								if (sounding_q) begin
									state_q <= S_LOAD;
								end else begin
									res_sample_q <= '0;
									res_active_q <= 1'b0;
									state_q      <= S_EMIT;
								end
							end
						endcase
					end
				end
				S_DIV: begin
					div_r_q   <= div_rem_next;
					div_n_q   <= div_n_next;
					div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(1)) begin
						level_q <= div_n_next[LEVEL_BITS-1:0];
						state_q <= S_IDLE;
					end
				end
				S_LOAD: begin
					neg_q        <= rom_q[SAMPLE_BITS-1];
					mul_a_q      <= {{LEVEL_BITS{1'b0}}, rom_abs[SAMPLE_BITS-2:0]};
					mul_b_q      <= level_q;
					mul_start_q  <= 1'b1;
					tmul_start_q <= 1'b1;
					state_q      <= S_MUL1;
				end
				S_MUL1: begin
					if (mul_done && tmul_done) begin
						if (tail_q != '0) begin
							mul_a_q     <= mul_p[MA_W-1:0];
							mul_b_q     <= tail_q;
							mul_start_q <= 1'b1;
							state_q     <= S_MUL2;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_MUL2: begin
					if (mul_done)
						state_q <= S_FIN;
				end
				S_FIN: begin
					res_sample_q <= neg_q ? (SAMPLE_BITS'(0) - mag_rnd) : mag_rnd;
					res_active_q <= 1'b1;
					phase_q      <= phase_q + inc_q;
					if (tail_q != '0) begin
						tail_q <= tail_new;
						if (tail_new <= thresh_q) begin
							sounding_q   <= 1'b0;
							inc_q        <= '0;
							res_active_q <= 1'b0;
						end
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= OUT_DATA_W'({res_active_q, res_sample_q});
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: test/sine_voice_with_decay_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sine voice: directed table, then random note sequences.
module sine_voice_with_decay_top_tb;
	import svd_pkg::*;

	localparam int SINE_BITS = DEF_SINE_INDEX_BITS;
	localparam int SMP_BITS = DEF_SAMPLE_BITS;
	localparam int RATE = DEF_SAMPLE_RATE;
	localparam int OUT_W = ((SMP_BITS + 8) / 8) * 8;
	localparam int QUARTER = 1 << (SINE_BITS - 2);
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] FULL_SCALE = (64'd1 << (SMP_BITS - 1)) - 64'd1;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 65;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic [SMP_BITS-1:0] smp;
		logic                active;
	} voice_out_t;

	typedef struct packed {
		action_t                  act;
		logic [NOTE_BITS-1:0]     note;
		logic [VEL_BITS-1:0]      vel;
		logic                     fixed;
		logic [SMP_BITS-1:0]      f_smp;
		logic                     f_active;
	} stim_row_t;

	localparam int DIRECTED_COUNT = 24;
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{ACT_TICK,      7'd0,   7'd0,   1'b1, 16'd0, 1'b0},
		'{ACT_STOP_TAIL, 7'd127, 7'd127, 1'b0, 16'd0, 1'b0},
		'{ACT_TICK,      7'd0,   7'd0,   1'b1, 16'd0, 1'b0},
		'{ACT_STOP_NOW,  7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
		'{ACT_TICK,      7'd127, 7'd127, 1'b1, 16'd0, 1'b0},
		'{ACT_START,     7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
		'{ACT_TICK,      7'd0,   7'd0,   1'b1, 16'd0, 1'b1},
		'{ACT_TICK,      7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
		'{ACT_START,     7'd127, 7'd127, 1'b0, 16'd0, 1'b0},
		'{ACT_TICK,      7'd0,   7'd0,   1'b1, 16'd0, 1'b1},
		'{ACT_TICK,      7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
		'{ACT_TICK,      7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
		'{ACT_START,     7'd69,  7'd127, 1'b0, 16'd0, 1'b0},
		'{ACT_TICK,      7'd0,   7'd0,   1'b1, 16'd0, 1'b1},
		'{ACT_TICK,      7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
		'{ACT_TICK,      7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
		'{ACT_STOP_TAIL, 7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
		'{ACT_TICK,      7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
		'{ACT_TICK,      7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
		'{ACT_STOP_TAIL, 7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
		'{ACT_TICK,      7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
		'{ACT_STOP_NOW,  7'd0,   7'd0,   1'b0, 16'd0, 1'b0},
		'{ACT_TICK,      7'd0,   7'd0,   1'b1, 16'd0, 1'b0},
		'{ACT_START,     7'd60,  7'd1,   1'b0, 16'd0, 1'b0}
	};

	localparam logic [LEVEL_BITS-1:0] PHASE_SETTINGS [6][3] = '{
		'{16'd9830,  16'd64881, 16'd164},
		'{16'd65535, 16'd0,     16'd0},
		'{16'd32768, 16'd60000, 16'd2000},
		'{16'd0,     16'd65535, 16'd32768},
		'{16'd0,     16'd0,     16'd0},
		'{16'd20000, 16'd50000, 16'd100}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;   // note_number, velocity
	logic [ACTION_BITS-1:0] s_axis_tuser = '0; // action
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;            // sample, voice_active
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [LEVEL_BITS-1:0] cfg_data = '0;

	logic signed [SMP_BITS-1:0] sine_table [1 << SINE_BITS];
	logic [PHASE_BITS-1:0] note_step_table [NOTE_COUNT];

	logic [LEVEL_BITS-1:0] cur_level_scale = LEVEL_SCALE_RST;
	logic [LEVEL_BITS-1:0] cur_decay = DECAY_RST;
	logic [LEVEL_BITS-1:0] cur_threshold = THRESH_RST;
	logic [PHASE_BITS-1:0] phase_acc = '0;
	logic [PHASE_BITS-1:0] phase_step = '0;
	logic [LEVEL_BITS-1:0] voice_lvl = '0;
	logic [LEVEL_BITS-1:0] tail_lvl = '0;
	logic sounding = 1'b0;

	voice_out_t expected_out [$];
	int errors = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;

	sine_voice_with_decay_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : build_tables
		logic [63:0] x, x2, term, sum, m, lo, hi, mid, p, a16, rt, v;
		logic [63:0] ratio [12];
		int unsigned quad, r, y, nm, oct, sh;
		for (int i = 0; i < (1 << SINE_BITS); i++) begin
			quad = i >> (SINE_BITS - 2);
			r = i & (QUARTER - 1);
			y = ((quad & 1) != 0) ? QUARTER - r : r;
			x = (HALF_PI_Q30 * 64'(y)) >> (SINE_BITS - 2);
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int k = 1; k <= 7; k++) begin
				term = (term * x2) >> 30;
				term = term / 64'((2 * k) * (2 * k + 1));
				if ((k % 2) != 0)
					sum = sum - term;
				else
					sum = sum + term;
			end
			if (sum > Q30_ONE)
				sum = Q30_ONE;
			m = (sum * FULL_SCALE + (64'd1 << 29)) >> 30;
			sine_table[i] = ((quad & 2) != 0) ? SMP_BITS'(64'd0 - m) : SMP_BITS'(m);
		end
		// twelfth root of two, Q2.30
		lo = Q30_ONE;
		hi = Q30_ONE + (64'd1 << 26);
		while (hi - lo > 64'd1) begin
			mid = (lo + hi) >> 1;
			p = mid;
			for (int j = 0; j < 11; j++)
				p = (p * mid) >> 30;
			if (p <= (64'd2 << 30))
				lo = mid;
			else
				hi = mid;
		end
		ratio[0] = Q30_ONE;
		for (int j = 1; j < 12; j++)
			ratio[j] = (ratio[j-1] * lo + (64'd1 << 29)) >> 30;
		a16 = ((64'd440 << 48) + 64'(RATE / 2)) / 64'(RATE);
		for (int n = 0; n < NOTE_COUNT; n++) begin
			nm = n + 3;
			oct = nm / 12;
			rt = ratio[nm % 12];
			v = a16 * (rt >> 15) + ((a16 * (rt & 64'h7FFF)) >> 15);
			sh = 37 - oct;
			note_step_table[n] = PHASE_BITS'((v + (64'd1 << (sh - 1))) >> sh);
		end
	end

	// returns 1 when the action yields a sample
	function automatic logic advance_voice(input action_t act, input logic [NOTE_BITS-1:0] note,
		input logic [VEL_BITS-1:0] vel, output voice_out_t res);
		logic signed [SMP_BITS-1:0] s;
		int sv;
		logic neg;
		logic [63:0] mag;
		logic has_res;
		has_res = 1'b0;
		res = '0;
		case (act)
			ACT_START: begin
				phase_acc = '0;
				tail_lvl = '0;
				phase_step = note_step_table[note];
				voice_lvl = LEVEL_BITS'((32'(vel) * 32'(cur_level_scale) + 32'd63) / 32'd127);
				sounding = 1'b1;
			end
			ACT_STOP_TAIL: begin
				if (tail_lvl == 0)
					tail_lvl = TAIL_ONE;
			end
			ACT_STOP_NOW: begin
				sounding = 1'b0;
				phase_step = '0;
			end
			ACT_TICK: begin
				has_res = 1'b1;
				if (sounding) begin
					s = sine_table[phase_acc >> (PHASE_BITS - SINE_BITS)];
					sv = s;
					neg = (sv < 0);
					mag = 64'(neg ? -sv : sv);
					mag = mag * 64'(voice_lvl);
					if (tail_lvl != 0) begin
						mag = mag * 64'(tail_lvl);
						mag = (mag + (64'd1 << 30)) >> 31;
					end else begin
						mag = (mag + (64'd1 << 15)) >> 16;
					end
					res.smp = neg ? SMP_BITS'(64'd0 - mag) : SMP_BITS'(mag);
					phase_acc = phase_acc + phase_step;
					if (tail_lvl != 0) begin
						tail_lvl = LEVEL_BITS'((32'(tail_lvl) * 32'(cur_decay) + 32'd32768) >> 16);
						if (tail_lvl <= cur_threshold) begin
							sounding = 1'b0;
							phase_step = '0;
						end
					end
				end
				res.active = sounding;
			end
		endcase
		return has_res;
	endfunction

	task automatic send_action(input action_t act, input logic [NOTE_BITS-1:0] note,
		input logic [VEL_BITS-1:0] vel, input logic fixed, input voice_out_t fixed_res);
		voice_out_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {{(IN_DATA_W - NOTE_BITS - VEL_BITS){1'b0}}, vel, note};
		do @(posedge clk); while (!s_axis_tready);
		if (advance_voice(act, note, vel, res))
			expected_out.push_back(fixed ? fixed_res : res);
		items_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_random(input action_t act);
		send_action(act, NOTE_BITS'($urandom), VEL_BITS'($urandom), 1'b0, '0);
	endtask

	always @(posedge clk) begin : result_check
		voice_out_t want;
		voice_out_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.smp = m_axis_tdata[SMP_BITS-1:0];
			got.active = m_axis_tdata[SMP_BITS];
			if (expected_out.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected sample transaction: sample %0d active %0b",
						$signed(got.smp), got.active);
			end else begin
				want = expected_out.pop_front();
				if (got.smp !== want.smp || got.active !== want.active) begin
					errors++;
					if (errors <= 10)
						$display("expected sample %0d active %0b, got %0d active %0b",
							$signed(want.smp), want.active, $signed(got.smp), got.active);
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sine_voice_with_decay_top: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		logic [LEVEL_BITS-1:0] vals [3];
		int target;
		int ticks;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_action(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].note, DIRECTED_ROWS[i].vel,
				DIRECTED_ROWS[i].fixed, '{DIRECTED_ROWS[i].f_smp, DIRECTED_ROWS[i].f_active});

		for (int p = 0; p < 6; p++) begin
			drain();
			for (int r = 0; r < 3; r++)
				vals[r] = (p == 4) ? LEVEL_BITS'($urandom) : PHASE_SETTINGS[p][r];
			for (int r = 0; r < 3; r++) begin
				cfg_valid <= 1'b1;
				cfg_index <= CFG_INDEX_BITS'(r);
				cfg_data <= vals[r];
				do @(posedge clk); while (!cfg_ready);
				case (reg_index_t'(r))
					REG_LEVEL_SCALE:    cur_level_scale = vals[r];
					REG_DECAY_FACTOR:   cur_decay = vals[r];
					REG_STOP_THRESHOLD: cur_threshold = vals[r];
					default: ;
				endcase
			end
			cfg_valid <= 1'b0;

			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			if (p == 4)
				hold_cycles = HOLD_OFF_CYCLES;

			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				if ($urandom_range(99) < 70) begin
					send_random(ACT_START);
					ticks = $urandom_range(1, 20);
					repeat (ticks) send_random(ACT_TICK);
					if ($urandom_range(2) != 0) begin
						send_random(ACT_STOP_TAIL);
						ticks = $urandom_range(0, 40);
						repeat (ticks) send_random(ACT_TICK);
					end else begin
						send_random(ACT_STOP_NOW);
						send_random(ACT_TICK);
					end
				end else begin
					send_random(action_t'($urandom_range(3)));
				end
			end
		end

		drain();
		if (errors == 0)
			$display("sine_voice_with_decay_top: match");
		else
			$display("sine_voice_with_decay_top: mismatch");
		$finish;
	end

endmodule
